>>> rtl/mbrot_pkg.sv
// ---------------------------------------------------------------------------
// mbrot_pkg
// Shared types, constants and the control-word ROM for the escape-time
// pixel engine.
// ---------------------------------------------------------------------------
package mbrot_pkg;

    // Fixed field and register widths
    localparam int PIX_W        = 9;
    localparam int COORD_W      = 32;
    localparam int LIMIT_W      = 16;
    localparam int DIFF_W       = COORD_W + 1;      // max - min
    localparam int MAP_W        = PIX_W + 1 + DIFF_W; // pixel * diff
    localparam int C_W          = MAP_W + 1;        // min + scaled step
    localparam int S_TDATA_W    = 24;               // 18 bits used
    localparam int M_TDATA_W    = 40;               // 35 bits used
    localparam int PADDR_W      = 5;
    localparam int PDATA_W      = 32;

    // Register map (index = paddr[4:2])
    typedef logic [2:0] reg_idx_t;
    localparam reg_idx_t REG_REAL_MIN   = 3'd0;
    localparam reg_idx_t REG_REAL_MAX   = 3'd1;
    localparam reg_idx_t REG_IMAG_MIN   = 3'd2;
    localparam reg_idx_t REG_IMAG_MAX   = 3'd3;
    localparam reg_idx_t REG_ITER_LIMIT = 3'd4;

    // Reset values
    localparam logic signed [COORD_W-1:0] RST_REAL_MIN = -32'sd536870912;
    localparam logic signed [COORD_W-1:0] RST_REAL_MAX = 32'sd268435456;
    localparam logic signed [COORD_W-1:0] RST_IMAG_MIN = -32'sd402653184;
    localparam logic signed [COORD_W-1:0] RST_IMAG_MAX = 32'sd402653184;
    localparam logic [LIMIT_W-1:0]        RST_ITER_LIMIT = 16'd50;

    // Sequencer step addresses
    typedef logic [3:0] step_t;
    localparam step_t ST_IDLE = 4'd0;
    localparam step_t ST_MAP0 = 4'd1;
    localparam step_t ST_MAP1 = 4'd2;
    localparam step_t ST_MAP2 = 4'd3;
    localparam step_t ST_INIT = 4'd4;
    localparam step_t ST_SQR  = 4'd5;
    localparam step_t ST_SQI  = 4'd6;
    localparam step_t ST_CRS  = 4'd7;
    localparam step_t ST_UPD  = 4'd8;
    localparam step_t ST_DONE = 4'd9;

    // Branch condition of a control word
    typedef enum logic [2:0] {
        COND_SEQ,       // fall through to next step
        COND_ACCEPT,    // go to target on input transaction, else hold
        COND_EXIT,      // go to target when loop exit, else fall through
        COND_JUMP,      // always go to target
        COND_OUTFREE    // go to target when output slot free, else hold
    } cond_t;

    // Multiplier operand select
    typedef enum logic [1:0] {
        MUL_RR,
        MUL_II,
        MUL_RI
    } mul_sel_t;

    typedef struct packed {
        cond_t    cond;
        step_t    target;
        mul_sel_t mul_sel;
        logic     ld_pix;
        logic     ld_diff;
        logic     ld_map;
        logic     ld_c;
        logic     ld_z0;
        logic     ld_sr;
        logic     ld_si;     // set in the step that also checks loop exit
        logic     upd;
        logic     ld_out;
    } ctrl_t;

    // Microcode ROM
    function automatic ctrl_t ucode(input step_t step);
        ctrl_t w;
        w = '{cond: COND_SEQ, target: ST_IDLE, mul_sel: MUL_RR, default: 1'b0};
        unique case (step)
            ST_IDLE: begin
                w.cond   = COND_ACCEPT;
                w.target = ST_MAP0;
                w.ld_pix = 1'b1;
            end
            ST_MAP0: w.ld_diff = 1'b1;
            ST_MAP1: w.ld_map  = 1'b1;
            ST_MAP2: w.ld_c    = 1'b1;
            ST_INIT: w.ld_z0   = 1'b1;
            ST_SQR:  w.mul_sel = MUL_RR;
            ST_SQI: begin
                w.mul_sel = MUL_II;
                w.ld_sr   = 1'b1;
            end
            ST_CRS: begin
                w.cond    = COND_EXIT;
                w.target  = ST_DONE;
                w.mul_sel = MUL_RI;
                w.ld_si   = 1'b1;
            end
            ST_UPD: begin
                w.cond   = COND_JUMP;
                w.target = ST_SQR;
                w.upd    = 1'b1;
            end
            ST_DONE: begin
                w.cond   = COND_OUTFREE;
                w.target = ST_IDLE;
                w.ld_out = 1'b1;
            end
            default: begin
                w.cond   = COND_JUMP;
                w.target = ST_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

>>> rtl/mandelbrot_escape_time_pixel.sv
// ---------------------------------------------------------------------------
// mandelbrot_escape_time_pixel
// Escape-time engine for one pixel per transaction, run by a microcoded
// sequencer over a single shared magnitude multiplier.
// ---------------------------------------------------------------------------
// Usage:
//  - Input stream (s_tvalid/s_tready/s_tdata) carries one pixel coordinate per
//    transaction. s_tready is high only while the sequencer sits in its idle
//    step, so one pixel is worked on at a time.
//  - The pixel is mapped into the window set over APB, then z = z*z + c is
//    iterated from z = c until |z|^2 >= 4 or the iteration limit is reached.
//  - Output stream (m_tvalid/m_tready/m_tdata) carries the echoed coordinate,
//    the iteration count and the inside flag, held in an output register.
//  - Sequence: the map steps form the window difference, the pixel product
//    and the offset c, then z is loaded; each iteration runs the three
//    multiplies (real square, imaginary square, cross) on the one shared
//    multiplier, then an update. After the last update the multiplies run
//    once more to check for exit, and the done step parks the result.
//  - If the receiver stalls with a result still parked, the sequencer holds
//    in its done step; the block takes a new pixel while the parked result
//    waits, but cannot finish that pixel until the slot frees.
//  - Reset (aresetn low, synchronous) loads the default window and limit,
//    clears the output valid and returns the sequencer to idle.
//  - Configuration must be written only while the block is idle; not enforced.
// ---------------------------------------------------------------------------
module mandelbrot_escape_time_pixel
    import mbrot_pkg::*;
#(
    parameter int IMAGE_WIDTH   = 512,
    parameter int IMAGE_HEIGHT  = 512,
    parameter int FRACTION_BITS = 28
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    // APB configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [PDATA_W-1:0]    pwdata,
    output logic [PDATA_W-1:0]    prdata,
    output logic                  pready,

    // Pixel input
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // [8:0] pixel_x, [17:9] pixel_y

    // Result output
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata    // [8:0] out_x, [17:9] out_y,
                                             // [33:18] iteration_count,
                                             // [34] inside_set
);

    localparam int FB   = FRACTION_BITS;
    localparam int LW   = $clog2(IMAGE_WIDTH);
    localparam int LH   = $clog2(IMAGE_HEIGHT);
    localparam int ZW   = FB + 4;            // signed z, range [-4, 4]
    localparam int MW   = FB + 3;            // |z|
    localparam int PW   = 2 * MW;            // multiplier product
    localparam int SQW  = FB + 5;            // square >> FB, up to 16.0
    localparam int XW   = FB + 6;            // cross >> (FB-1), up to 32.0
    localparam int SW   = ((XW > C_W) ? XW : C_W) + 2;  // update sums
    localparam int PAD_W = M_TDATA_W - (2 * PIX_W + LIMIT_W + 1);

    localparam logic signed [SW-1:0] Z_LIM  =
        {{(SW-FB-3){1'b0}}, 3'b100, {FB{1'b0}}};
    localparam logic signed [SW-1:0] Z_NLIM = -Z_LIM;
    localparam logic [XW-1:0]        ESC_LIM = {4'b0001, {(FB+2){1'b0}}};

    // ---------------- configuration registers ----------------
    logic signed [COORD_W-1:0] real_min_reg, real_max_reg;
    logic signed [COORD_W-1:0] imag_min_reg, imag_max_reg;
    logic [LIMIT_W-1:0]        limit_reg;
    logic                      cfg_wr;
    reg_idx_t                  cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            real_min_reg <= RST_REAL_MIN;
            real_max_reg <= RST_REAL_MAX;
            imag_min_reg <= RST_IMAG_MIN;
            imag_max_reg <= RST_IMAG_MAX;
            limit_reg    <= RST_ITER_LIMIT;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_REAL_MIN:   real_min_reg <= pwdata;
                REG_REAL_MAX:   real_max_reg <= pwdata;
                REG_IMAG_MIN:   imag_min_reg <= pwdata;
                REG_IMAG_MAX:   imag_max_reg <= pwdata;
                REG_ITER_LIMIT: limit_reg    <= pwdata[LIMIT_W-1:0];
                default: ;                        // unmapped: ignored
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_REAL_MIN:   prdata = real_min_reg;
            REG_REAL_MAX:   prdata = real_max_reg;
            REG_IMAG_MIN:   prdata = imag_min_reg;
            REG_IMAG_MAX:   prdata = imag_max_reg;
            REG_ITER_LIMIT: prdata = {{(PDATA_W-LIMIT_W){1'b0}}, limit_reg};
            default:        prdata = '0;
        endcase
    end

    // ---------------- sequencer ----------------
    step_t step_reg, step_next;
    ctrl_t cw;
    logic  s_fire;
    logic  loop_exit;
    logic  out_free;
    logic  m_tvalid_reg, m_tvalid_next;

    assign cw       = ucode(step_reg);
    assign s_tready = (step_reg == ST_IDLE);
    assign s_fire   = s_tvalid & s_tready;
    assign out_free = ~m_tvalid_reg | m_tready;

    always_comb begin
        unique case (cw.cond)
            COND_SEQ:     step_next = step_reg + step_t'(1);
            COND_ACCEPT:  step_next = s_fire ? cw.target : step_reg;
            COND_EXIT:    step_next = loop_exit ? cw.target : step_reg + step_t'(1);
            COND_JUMP:    step_next = cw.target;
            COND_OUTFREE: step_next = out_free ? cw.target : step_reg;
            default:      step_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= ST_IDLE;
        end else begin
            step_reg <= step_next;
        end
    end

    // ---------------- window mapping ----------------
    logic [PIX_W-1:0]         px_reg, py_reg;
    logic signed [DIFF_W-1:0] diff_r_reg, diff_i_reg;
    logic signed [MAP_W-1:0]  map_r_reg, map_i_reg;
    logic signed [C_W-1:0]    cr_reg, ci_reg;

    always_ff @(posedge aclk) begin
        if (cw.ld_pix && s_fire) begin
            px_reg <= s_tdata[PIX_W-1:0];
            py_reg <= s_tdata[2*PIX_W-1:PIX_W];
        end
        if (cw.ld_diff) begin
            diff_r_reg <= DIFF_W'(real_max_reg) - DIFF_W'(real_min_reg);
            diff_i_reg <= DIFF_W'(imag_max_reg) - DIFF_W'(imag_min_reg);
        end
        if (cw.ld_map) begin
            map_r_reg <= MAP_W'($signed({1'b0, px_reg}) * diff_r_reg);
            map_i_reg <= MAP_W'($signed({1'b0, py_reg}) * diff_i_reg);
        end
        // floor division by a power-of-two size is an arithmetic shift
        if (cw.ld_c) begin
            cr_reg <= C_W'(map_r_reg >>> LW) + C_W'(real_min_reg);
            ci_reg <= C_W'(map_i_reg >>> LH) + C_W'(imag_min_reg);
        end
    end

    // ---------------- iteration datapath ----------------
    function automatic logic signed [ZW-1:0] clamp_z(input logic signed [SW-1:0] v);
        logic signed [ZW-1:0] r;
        if (v > Z_LIM) begin
            r = Z_LIM[ZW-1:0];
        end else if (v < Z_NLIM) begin
            r = Z_NLIM[ZW-1:0];
        end else begin
            r = v[ZW-1:0];
        end
        return r;
    endfunction

    logic signed [ZW-1:0] zr_reg, zi_reg;
    logic [LIMIT_W-1:0]   n_reg;
    logic [PW-1:0]        prod_reg;
    logic [SQW-1:0]       sr_reg, si_reg;
    logic [ZW-1:0]        zr_neg, zi_neg;
    logic [MW-1:0]        zr_mag, zi_mag;
    logic [MW-1:0]        mul_a, mul_b;
    logic [SQW-1:0]       sq_now;
    logic [XW-1:0]        cross_now;
    logic [XW-1:0]        mag_sum;
    logic signed [SW-1:0] nr_sum, ni_sum, cross_ext;
    logic                 cross_neg;

    assign zr_neg = -zr_reg;
    assign zi_neg = -zi_reg;
    assign zr_mag = zr_reg[ZW-1] ? zr_neg[MW-1:0] : zr_reg[MW-1:0];
    assign zi_mag = zi_reg[ZW-1] ? zi_neg[MW-1:0] : zi_reg[MW-1:0];

    always_comb begin
        unique case (cw.mul_sel)
            MUL_RR:  begin mul_a = zr_mag; mul_b = zr_mag; end
            MUL_II:  begin mul_a = zi_mag; mul_b = zi_mag; end
            MUL_RI:  begin mul_a = zr_mag; mul_b = zi_mag; end
            default: begin mul_a = zr_mag; mul_b = zr_mag; end
        endcase
    end

    // truncated square and doubled cross product
    assign sq_now    = prod_reg[2*FB+4:FB];
    assign cross_now = prod_reg[2*FB+4:FB-1];

    // exit: limit reached, or |z|^2 of the last update reached 4
    assign mag_sum   = XW'(sr_reg) + XW'(sq_now);
    assign loop_exit = (n_reg == limit_reg) ||
                       ((n_reg != '0) && (mag_sum >= ESC_LIM));

    assign cross_neg = zr_reg[ZW-1] ^ zi_reg[ZW-1];
    assign cross_ext = cross_neg ? -$signed(SW'(cross_now)) : $signed(SW'(cross_now));
    assign nr_sum    = $signed(SW'(sr_reg)) - $signed(SW'(si_reg)) + SW'(cr_reg);
    assign ni_sum    = cross_ext + SW'(ci_reg);

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        if (cw.ld_sr) begin
            sr_reg <= sq_now;
        end
        if (cw.ld_si) begin
            si_reg <= sq_now;
        end
        if (cw.ld_z0) begin
            zr_reg <= clamp_z(SW'(cr_reg));
            zi_reg <= clamp_z(SW'(ci_reg));
        end else if (cw.upd) begin
            zr_reg <= clamp_z(nr_sum);
            zi_reg <= clamp_z(ni_sum);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            n_reg <= '0;
        end else if (cw.ld_z0) begin
            n_reg <= '0;
        end else if (cw.upd) begin
            n_reg <= n_reg + LIMIT_W'(1);
        end
    end

    // ---------------- output register ----------------
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic                 out_load;

    assign out_load      = cw.ld_out & out_free;
    assign m_tvalid_next = out_load | (m_tvalid_reg & ~m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= {{PAD_W{1'b0}}, (n_reg == limit_reg), n_reg, py_reg, px_reg};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
